/* hdl/pncr_pkg.sv */
// Package for the palette nearest-color remap unit.
// Shared constants, payload types, pipeline tag and state encoding; no dependencies.
package pncr_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(PALETTE_ENTRIES + 1);
    localparam int CH_W   = 8;
    localparam int SQ_W   = 2 * CH_W;
    localparam int DIST_W = SQ_W + 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_REMAP = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FETCH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        t_cmd            command;
        logic [7:0]      entry_index;
        logic [CH_W-1:0] old_red;
        logic [CH_W-1:0] old_green;
        logic [CH_W-1:0] old_blue;
        logic [CH_W-1:0] new_red;
        logic [CH_W-1:0] new_green;
        logic [CH_W-1:0] new_blue;
        logic [CH_W-1:0] pix_red;
        logic [CH_W-1:0] pix_green;
        logic [CH_W-1:0] pix_blue;
        logic [CH_W-1:0] pix_alpha;
    } t_req;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
        logic [7:0]      nearest_index;
        logic            replaced;
        logic            skipped;
    } t_rsp;

    // travels alongside a palette entry through the read and distance stages
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

/* hdl/pncr_if.sv */
// Valid/ready channel interfaces for request and response of the remap unit.
// Depends on pncr_pkg.
interface pncr_in_if;
    import pncr_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pncr_out_if;
    import pncr_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/palette_nearest_color_remap_unit.sv */
// Palette remap unit top: sequencer, search compare, output register. Depends on pncr_pkg,
// pncr_if, pncr_palette_mem and pncr_dist_unit. Load request: accepted in idle, no response.
// Remap: 256 reads, one per cycle, through the memory read register, one shared distance unit
// (distance register), compare, best-entry fetch and emit; next request is accepted in the cycle
// after emit. Zero-alpha skip: goes from accept straight to emit; full output stalls emit.
// Synchronous active-low reset clears control state and alpha_mode; palettes are not cleared.
module palette_nearest_color_remap_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    pncr_in_if.sink    i_req,
    pncr_out_if.source o_rsp
);
    import pncr_pkg::*;

    // ---- state ----
    t_state             r_state, n_state;
    logic               r_alpha_mode;
    t_rgb               r_pix;          // pixel under search
    logic [CH_W-1:0]    r_alpha;
    logic               r_skip;         // transparent pixel, bypasses search
    logic [CNT_W-1:0]   r_addr;         // next palette entry to read
    t_tag               r_tag1;         // aligned with memory read data
    logic [IDX_W-1:0]   r_best;
    logic [DIST_W-1:0]  r_best_gap;
    t_rsp               r_rsp;
    logic               r_rsp_vld;

    // ---- combinational ----
    logic               req_fire;
    logic               is_remap;
    logic               is_skip;
    logic               load_we;
    logic               issue;
    logic               out_free;
    logic               emit;
    logic               best_upd;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    t_rgb               rd_old, rd_new;
    t_rgb               wr_old, wr_new;
    t_tag               dist_tag;
    logic [DIST_W-1:0]  entry_gap;
    t_rsp               rsp_nxt;

    assign req_fire = i_req.valid && i_req.ready;
    assign is_remap = (i_req.data.command == CMD_REMAP);
    assign is_skip  = r_alpha_mode && (i_req.data.pix_alpha == '0);
    // entries beyond the palette depth are dropped
    assign load_we  = req_fire && !is_remap &&
                      ({1'b0, i_req.data.entry_index} < 9'(PALETTE_ENTRIES));
    assign out_free = !r_rsp_vld || o_rsp.ready;

    assign wr_old = '{red: i_req.data.old_red, green: i_req.data.old_green,
                      blue: i_req.data.old_blue};
    assign wr_new = '{red: i_req.data.new_red, green: i_req.data.new_green,
                      blue: i_req.data.new_blue};

    // ---- sequencer: next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire && is_remap) begin
                    n_state = is_skip ? ST_EMIT : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // last entry leaves the distance unit
                if (dist_tag.vld && dist_tag.idx == LAST_IDX) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- sequencer: outputs ----
    always_comb begin
        i_req.ready = 1'b0;
        issue       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_addr[IDX_W-1:0];
        emit        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_SEARCH: begin
                issue = (r_addr < CNT_W'(PALETTE_ENTRIES));
                rd_en = issue;
            end
            ST_FETCH: begin
                // reread the winner to get both old and new colors
                rd_en   = 1'b1;
                rd_addr = r_best;
            end
            ST_EMIT: begin
                emit = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_alpha_mode <= i_cfg_wdata;
        end
    end

    // ---- pixel capture and read address counter ----
    always_ff @(posedge i_clk) begin
        if (req_fire && is_remap) begin
            r_pix   <= '{red: i_req.data.pix_red, green: i_req.data.pix_green,
                         blue: i_req.data.pix_blue};
            r_alpha <= i_req.data.pix_alpha;
            r_skip  <= is_skip;
            r_addr  <= '0;
        end else if (issue) begin
            r_addr  <= r_addr + CNT_W'(1);
        end
    end

    // ---- tag alongside memory read data ----
    always_ff @(posedge i_clk) begin
        r_tag1.idx <= r_addr[IDX_W-1:0];
        if (!i_rst_n) begin
            r_tag1.vld <= 1'b0;
        end else begin
            r_tag1.vld <= issue;
        end
    end

    pncr_palette_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_req.data.entry_index[IDX_W-1:0]),
        .i_wold  (wr_old),
        .i_wnew  (wr_new),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rold  (rd_old),
        .o_rnew  (rd_new)
    );

    pncr_dist_unit u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (rd_old),
        .i_pixel (r_pix),
        .i_tag   (r_tag1),
        .o_dist  (entry_gap),
        .o_tag   (dist_tag)
    );

    // ---- running minimum; entry 0 always seeds it, strict less keeps lowest index ----
    assign best_upd = dist_tag.vld && ((dist_tag.idx == '0) || (entry_gap < r_best_gap));

    always_ff @(posedge i_clk) begin
        if (best_upd) begin
            r_best     <= dist_tag.idx;
            r_best_gap <= entry_gap;
        end
    end

    // ---- result build ----
    always_comb begin
        rsp_nxt.out_alpha = r_alpha;
        if (r_skip) begin
            rsp_nxt.out_red       = r_pix.red;
            rsp_nxt.out_green     = r_pix.green;
            rsp_nxt.out_blue      = r_pix.blue;
            rsp_nxt.nearest_index = '0;
            rsp_nxt.replaced      = 1'b0;
            rsp_nxt.skipped       = 1'b1;
        end else begin
            rsp_nxt.nearest_index = 8'(r_best);
            rsp_nxt.skipped       = 1'b0;
            rsp_nxt.replaced      = (rd_old != rd_new);
            if (rd_old != rd_new) begin
                rsp_nxt.out_red   = rd_new.red;
                rsp_nxt.out_green = rd_new.green;
                rsp_nxt.out_blue  = rd_new.blue;
            end else begin
                rsp_nxt.out_red   = r_pix.red;
                rsp_nxt.out_green = r_pix.green;
                rsp_nxt.out_blue  = r_pix.blue;
            end
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_rsp <= rsp_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_vld <= 1'b0;
        end else if (emit) begin
            r_rsp_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_vld <= 1'b0;
        end
    end

    assign o_rsp.valid = r_rsp_vld;
    assign o_rsp.data  = r_rsp;

`ifndef ASSERT_OFF
    a_tag_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_tag.vld |-> (r_state == ST_SEARCH))
        else $error("distance result outside search");

    a_all_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH && n_state == ST_FETCH) |-> (r_addr == CNT_W'(PALETTE_ENTRIES)))
        else $error("search ended before all entries were read");

    a_fetch_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |=> (r_state == ST_EMIT))
        else $error("fetch not followed by emit");

    a_skip_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_vld && r_rsp.skipped) |-> (!r_rsp.replaced && r_rsp.nearest_index == '0))
        else $error("skipped response carries search fields");
`endif

endmodule

/* hdl/pncr_palette_mem.sv */
// Old and new palette storage: one write port, one registered read port.
// Depends on pncr_pkg.
module pncr_palette_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [pncr_pkg::IDX_W-1:0] i_waddr,
    input  pncr_pkg::t_rgb             i_wold,
    input  pncr_pkg::t_rgb             i_wnew,
    input  logic                       i_re,
    input  logic [pncr_pkg::IDX_W-1:0] i_raddr,
    output pncr_pkg::t_rgb             o_rold,
    output pncr_pkg::t_rgb             o_rnew
);
    import pncr_pkg::*;

    t_rgb r_old_mem [PALETTE_ENTRIES];
    t_rgb r_new_mem [PALETTE_ENTRIES];
    t_rgb r_rold;
    t_rgb r_rnew;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_old_mem[i_waddr] <= i_wold;
            r_new_mem[i_waddr] <= i_wnew;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rold <= r_old_mem[i_raddr];
            r_rnew <= r_new_mem[i_raddr];
        end
    end

    assign o_rold = r_rold;
    assign o_rnew = r_rnew;

endmodule

/* hdl/pncr_dist_unit.sv */
// Shared squared-RGB-distance unit: squares registered, sum combinational.
// Depends on pncr_pkg.
module pncr_dist_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pncr_pkg::t_rgb              i_entry,
    input  pncr_pkg::t_rgb              i_pixel,
    input  pncr_pkg::t_tag              i_tag,
    output logic [pncr_pkg::DIST_W-1:0] o_dist,
    output pncr_pkg::t_tag              o_tag
);
    import pncr_pkg::*;

    logic [CH_W-1:0] d_r, d_g, d_b;
    logic [SQ_W-1:0] r_sq_r, r_sq_g, r_sq_b;
    t_tag            r_tag;

    assign d_r = (i_entry.red   > i_pixel.red)   ? i_entry.red   - i_pixel.red
                                                 : i_pixel.red   - i_entry.red;
    assign d_g = (i_entry.green > i_pixel.green) ? i_entry.green - i_pixel.green
                                                 : i_pixel.green - i_entry.green;
    assign d_b = (i_entry.blue  > i_pixel.blue)  ? i_entry.blue  - i_pixel.blue
                                                 : i_pixel.blue  - i_entry.blue;

    always_ff @(posedge i_clk) begin
        r_sq_r <= SQ_W'(d_r) * SQ_W'(d_r);
        r_sq_g <= SQ_W'(d_g) * SQ_W'(d_g);
        r_sq_b <= SQ_W'(d_b) * SQ_W'(d_b);
    end

    always_ff @(posedge i_clk) begin
        r_tag.idx <= i_tag.idx;
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
        end else begin
            r_tag.vld <= i_tag.vld;
        end
    end

    assign o_dist = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);
    assign o_tag  = r_tag;

endmodule
